// File: rtl/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test unit.
// No dependencies; used by rtl/ray_box_slab_test_unit.sv.
`default_nettype none
package rbst_pkg;

    // Number of restoring division steps, one quotient bit per stage.
    localparam int DIV_STEPS = 49;
    localparam int LANES = 6;
    localparam int AXES = 3;

    localparam logic [48:0] T_POS_MAX = 49'h0_7FFF_FFFF_FFFF;
    localparam logic [48:0] T_NEG_MAG = 49'h0_8000_0000_0000;
    localparam logic [63:0] PROD_CLAMP = 64'h0000_0100_0000_0000;

    // One divider lane: partial remainder, dividend/quotient shift word, sign.
    typedef struct packed {
        logic [31:0] rem;
        logic [48:0] nq;
        logic        neg;
    } lane_t;

    // Ray data that travels with each request through the pipeline.
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0]       dneg;
        logic [2:0][31:0] den;
    } ray_t;

endpackage
`default_nettype wire

// File: rtl/ray_box_slab_test_unit.sv
// Ray versus axis-aligned box slab test, fully pipelined top level.
// Depends on rtl/rbst_pkg.sv for types and constants.
`default_nettype none

// One request per clock is accepted and one result per clock is delivered.
// The pipeline has one prepare stage, 49 restoring-division stages (one
// quotient bit per stage, six lanes in parallel for the two slab planes of
// each axis), then seven stages for saturation, slab ordering, entry and
// exit selection, the hit decision, the entry point multiply and the origin
// addition.
// Backpressure stalls the whole pipeline in place.
module ray_box_slab_test_unit
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
    // box_min_z, box_max_x, box_max_y, box_max_z (32 bits each, lowest first)
    input  wire logic [383:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit[0], entry_distance[48:1], hit_x[80:49], hit_y[112:81],
    // hit_z[144:113], zero fill [151:145]
    output logic [151:0]      m_tdata
);

    localparam int NS = rbst_pkg::DIV_STEPS;

    logic en;

    // Divider pipeline storage.
    logic                  dv_reg   [0:NS];
    rbst_pkg::lane_t       lane_reg [0:NS][0:rbst_pkg::LANES-1];
    rbst_pkg::lane_t       lane_next[1:NS][0:rbst_pkg::LANES-1];
    rbst_pkg::ray_t        ray_reg  [0:NS];

    // Post-division stages.
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    rbst_pkg::ray_t        r1_reg, r2_reg, r3_reg, r4_reg, r5_reg, r6_reg;
    logic signed [47:0]    t_reg    [0:rbst_pkg::LANES-1];
    logic signed [47:0]    near_reg [0:rbst_pkg::AXES-1];
    logic signed [47:0]    far_reg  [0:rbst_pkg::AXES-1];
    logic signed [47:0]    tmin3_reg, tmax3_reg, tmin4_reg, tmin5_reg, tmin6_reg;
    logic                  hit4_reg, hit5_reg, hit6_reg, out_hit_reg;
    logic [47:0]           a_reg;
    logic                  tneg4_reg;
    logic [2:0]            sneg5_reg, sneg6_reg;
    logic [63:0]           phi_reg  [0:rbst_pkg::AXES-1];
    logic [31:0]           plo_reg  [0:rbst_pkg::AXES-1];
    logic [40:0]           p_reg    [0:rbst_pkg::AXES-1];
    logic [47:0]           out_t_reg;
    logic [31:0]           out_c_reg[0:rbst_pkg::AXES-1];

    assign en = !v7_reg || m_tready;
    assign s_tready = en;

    // Prepare stage: fix zero directions, form magnitudes and signs.
    logic                  dv_next0;
    rbst_pkg::lane_t       lane_next0[0:rbst_pkg::LANES-1];
    rbst_pkg::ray_t        ray_next0;

    always_comb
    begin
        logic signed [31:0] o, d, c;
        logic signed [32:0] diff;
        logic [32:0]        mag;
        dv_next0 = s_tvalid;
        ray_next0 = '0;
        for (int ax = 0; ax < rbst_pkg::AXES; ax++)
        begin
            o = s_tdata[32*ax +: 32];
            d = s_tdata[32*(3+ax) +: 32];
            if (d == 32'sd0)
            begin
                d = 32'sd1;
            end
            ray_next0.org[ax] = o;
            ray_next0.dneg[ax] = d[31];
            ray_next0.den[ax] = d[31] ? (32'd0 - d) : d;
            for (int k = 0; k < 2; k++)
            begin
                c = s_tdata[32*(6+3*k+ax) +: 32];
                diff = 33'(c) - 33'(o);
                mag = diff[32] ? (33'd0 - diff) : diff;
                lane_next0[2*ax+k].rem = '0;
                lane_next0[2*ax+k].nq = {mag, 16'd0};
                lane_next0[2*ax+k].neg = diff[32] ^ d[31];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= dv_next0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg[0] <= ray_next0;
            for (int l = 0; l < rbst_pkg::LANES; l++)
            begin
                lane_reg[0][l] <= lane_next0[l];
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar s = 0; s < NS; s++)
    begin : g_div
        always_comb
        begin
            logic [32:0] rem_sh;
            logic [32:0] den_x;
            logic        ge;
            for (int l = 0; l < rbst_pkg::LANES; l++)
            begin
                rem_sh = {lane_reg[s][l].rem, lane_reg[s][l].nq[48]};
                den_x = {1'b0, ray_reg[s].den[l/2]};
                ge = rem_sh >= den_x;
                lane_next[s+1][l].rem = ge ? 32'(rem_sh - den_x) : rem_sh[31:0];
                lane_next[s+1][l].nq = {lane_reg[s][l].nq[47:0], ge};
                lane_next[s+1][l].neg = lane_reg[s][l].neg;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ray_reg[s+1] <= ray_reg[s];
                for (int l = 0; l < rbst_pkg::LANES; l++)
                begin
                    lane_reg[s+1][l] <= lane_next[s+1][l];
                end
            end
        end
    end

    // Valid bits of the stages after the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= dv_reg[NS];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Datapath of the stages after the divider.
    always_ff @(posedge clk)
    begin
        logic [48:0]        q;
        logic signed [47:0] mx, mn;
        logic [63:0]        psum;
        logic signed [42:0] ssum;
        if (en)
        begin
            // Saturate each quotient to a signed 48-bit distance.
            r1_reg <= ray_reg[NS];
            for (int l = 0; l < rbst_pkg::LANES; l++)
            begin
                q = lane_reg[NS][l].nq;
                if (!lane_reg[NS][l].neg)
                begin
                    t_reg[l] <= (q > rbst_pkg::T_POS_MAX) ? 48'(rbst_pkg::T_POS_MAX)
                                                          : 48'(q);
                end
                else
                begin
                    if (q > rbst_pkg::T_NEG_MAG)
                    begin
                        q = rbst_pkg::T_NEG_MAG;
                    end
                    t_reg[l] <= 48'(49'd0 - q);
                end
            end

            // Order the two slab distances of each axis.
            r2_reg <= r1_reg;
            for (int ax = 0; ax < rbst_pkg::AXES; ax++)
            begin
                if (t_reg[2*ax] < t_reg[2*ax+1])
                begin
                    near_reg[ax] <= t_reg[2*ax];
                    far_reg[ax] <= t_reg[2*ax+1];
                end
                else
                begin
                    near_reg[ax] <= t_reg[2*ax+1];
                    far_reg[ax] <= t_reg[2*ax];
                end
            end

            // Entry is the largest near distance, exit the smallest far one.
            r3_reg <= r2_reg;
            mx = near_reg[0];
            mn = far_reg[0];
            for (int ax = 1; ax < rbst_pkg::AXES; ax++)
            begin
                if (near_reg[ax] > mx)
                begin
                    mx = near_reg[ax];
                end
                if (far_reg[ax] < mn)
                begin
                    mn = far_reg[ax];
                end
            end
            tmin3_reg <= mx;
            tmax3_reg <= mn;

            // Hit decision and entry magnitude.
            r4_reg <= r3_reg;
            tmin4_reg <= tmin3_reg;
            hit4_reg <= tmax3_reg > (tmin3_reg[47] ? 48'sd0 : tmin3_reg);
            a_reg <= tmin3_reg[47] ? (48'd0 - tmin3_reg) : tmin3_reg;
            tneg4_reg <= tmin3_reg[47];

            // Partial products of entry distance times direction.
            r5_reg <= r4_reg;
            tmin5_reg <= tmin4_reg;
            hit5_reg <= hit4_reg;
            for (int ax = 0; ax < rbst_pkg::AXES; ax++)
            begin
                phi_reg[ax] <= a_reg[47:16] * r4_reg.den[ax];
                plo_reg[ax] <= 32'((48'(a_reg[15:0]) * 48'(r4_reg.den[ax])) >> 16);
                sneg5_reg[ax] <= tneg4_reg ^ r4_reg.dneg[ax];
            end

            // Sum the partial products and clamp the magnitude.
            r6_reg <= r5_reg;
            tmin6_reg <= tmin5_reg;
            hit6_reg <= hit5_reg;
            sneg6_reg <= sneg5_reg;
            for (int ax = 0; ax < rbst_pkg::AXES; ax++)
            begin
                psum = phi_reg[ax] + 64'(plo_reg[ax]);
                p_reg[ax] <= (psum > rbst_pkg::PROD_CLAMP) ? 41'(rbst_pkg::PROD_CLAMP)
                                                           : psum[40:0];
            end

            // Add the origin, saturate, and zero the point on a miss.
            out_t_reg <= tmin6_reg;
            out_hit_reg <= hit6_reg;
            for (int ax = 0; ax < rbst_pkg::AXES; ax++)
            begin
                ssum = 43'(signed'(r6_reg.org[ax]));
                ssum = sneg6_reg[ax] ? (ssum - 43'(p_reg[ax])) : (ssum + 43'(p_reg[ax]));
                if (!hit6_reg)
                begin
                    out_c_reg[ax] <= '0;
                end
                else if (ssum > 43'sh0_7FFF_FFFF)
                begin
                    out_c_reg[ax] <= 32'h7FFF_FFFF;
                end
                else if (ssum < -43'sh0_8000_0000)
                begin
                    out_c_reg[ax] <= 32'h8000_0000;
                end
                else
                begin
                    out_c_reg[ax] <= ssum[31:0];
                end
            end
        end
    end

    assign m_tvalid = v7_reg;
    assign m_tdata = {7'd0, out_c_reg[2], out_c_reg[1], out_c_reg[0], out_t_reg, out_hit_reg};

    // The final remainder of the first lane of every valid division is below its divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[NS] |-> (lane_reg[NS][0].rem < ray_reg[NS].den[0]))
        else $error("divider remainder out of range");

    // A miss carries zero x and z coordinates of the entry point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && !out_hit_reg) |-> (out_c_reg[0] == 32'd0 && out_c_reg[2] == 32'd0))
        else $error("entry point not cleared on a miss");

    // A stalled result keeps its valid bit and entry distance, and the stage before it keeps its valid bit.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && !m_tready) |=> (v7_reg && $stable(v6_reg) && $stable(out_t_reg)))
        else $error("pipeline moved during a stall");

    // A hit never has its entry distance at the positive limit.
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && hit4_reg) |-> (tmin4_reg != 48'sh7FFF_FFFF_FFFF))
        else $error("hit with entry at the positive limit");

endmodule
`default_nettype wire
